/* hdl/msd_pkg.sv */
// Shared constants, types and the Morse code table of the stream decoder.
package msd_pkg;

    // Longest dot/dash pattern that the symbol buffer holds (legal range 10 to 16).
    localparam int MaxCodeLen = 10;
    localparam int LenW       = $clog2(MaxCodeLen + 1);

    // Table entries carry their pattern at the widest legal buffer size.
    localparam int TableBitsW = 16;
    localparam int TableLenW  = 5;
    localparam int CodeCount  = 54;

    localparam logic [7:0] AsciiSpace = 8'h20;
    localparam logic [7:0] AsciiDot   = 8'h2E;
    localparam logic [7:0] AsciiDash  = 8'h2D;
    localparam logic [7:0] AsciiSlash = 8'h2F;

    localparam logic [6:0] CharSpace  = 7'd32;
    localparam logic [6:0] CharNone   = 7'd0;

    typedef logic [MaxCodeLen-1:0] pattern_t;
    typedef logic [LenW-1:0]       pattern_len_t;

    typedef struct packed {
        logic [TableLenW-1:0]  len;
        logic [TableBitsW-1:0] bits;
        logic [6:0]            ch;
    } code_entry_t;

    // Dash is 1, dot is 0, first symbol in the highest used bit.
    localparam code_entry_t CodeTable [CodeCount] = '{
        '{5'd2,  16'b01,         7'h61}, // a
        '{5'd4,  16'b1000,       7'h62}, // b
        '{5'd4,  16'b1010,       7'h63}, // c
        '{5'd3,  16'b100,        7'h64}, // d
        '{5'd1,  16'b0,          7'h65}, // e
        '{5'd4,  16'b0010,       7'h66}, // f
        '{5'd3,  16'b110,        7'h67}, // g
        '{5'd4,  16'b0000,       7'h68}, // h
        '{5'd2,  16'b00,         7'h69}, // i
        '{5'd4,  16'b0111,       7'h6A}, // j
        '{5'd3,  16'b101,        7'h6B}, // k
        '{5'd4,  16'b0100,       7'h6C}, // l
        '{5'd2,  16'b11,         7'h6D}, // m
        '{5'd2,  16'b10,         7'h6E}, // n
        '{5'd3,  16'b111,        7'h6F}, // o
        '{5'd4,  16'b0110,       7'h70}, // p
        '{5'd4,  16'b1101,       7'h71}, // q
        '{5'd3,  16'b010,        7'h72}, // r
        '{5'd3,  16'b000,        7'h73}, // s
        '{5'd1,  16'b1,          7'h74}, // t
        '{5'd3,  16'b001,        7'h75}, // u
        '{5'd4,  16'b0001,       7'h76}, // v
        '{5'd3,  16'b011,        7'h77}, // w
        '{5'd4,  16'b1001,       7'h78}, // x
        '{5'd4,  16'b1011,       7'h79}, // y
        '{5'd4,  16'b1100,       7'h7A}, // z
        '{5'd5,  16'b01111,      7'h31}, // 1
        '{5'd5,  16'b00111,      7'h32}, // 2
        '{5'd5,  16'b00011,      7'h33}, // 3
        '{5'd5,  16'b00001,      7'h34}, // 4
        '{5'd5,  16'b00000,      7'h35}, // 5
        '{5'd5,  16'b10000,      7'h36}, // 6
        '{5'd5,  16'b11000,      7'h37}, // 7
        '{5'd5,  16'b11100,      7'h38}, // 8
        '{5'd5,  16'b11110,      7'h39}, // 9
        '{5'd5,  16'b11111,      7'h30}, // 0
        '{5'd6,  16'b010101,     7'h2E}, // full stop
        '{5'd6,  16'b110011,     7'h2C}, // comma
        '{5'd6,  16'b001100,     7'h3F}, // question mark
        '{5'd6,  16'b011110,     7'h27}, // apostrophe
        '{5'd10, 16'b1010111110, 7'h21}, // exclamation mark
        '{5'd5,  16'b10010,      7'h2F}, // slash
        '{5'd5,  16'b10110,      7'h28}, // open parenthesis
        '{5'd6,  16'b101101,     7'h29}, // close parenthesis
        '{5'd5,  16'b01000,      7'h26}, // ampersand
        '{5'd6,  16'b111000,     7'h3A}, // colon
        '{5'd6,  16'b101010,     7'h3B}, // semicolon
        '{5'd5,  16'b10001,      7'h3D}, // equals
        '{5'd5,  16'b01010,      7'h2B}, // plus
        '{5'd6,  16'b100001,     7'h2D}, // hyphen
        '{5'd6,  16'b001101,     7'h5F}, // underscore
        '{5'd6,  16'b010010,     7'h22}, // double quote
        '{5'd7,  16'b0001001,    7'h24}, // dollar
        '{5'd6,  16'b011010,     7'h40}  // at sign
    };

    // Parallel match against every table entry; the first entry that matches wins.
    function automatic logic [6:0] lookup_code(input pattern_len_t len, input pattern_t bits);
        logic [6:0] ch;
        ch = CharNone;
        for (int i = CodeCount - 1; i >= 0; i--) begin
            if ((CodeTable[i].len == TableLenW'(len)) &&
                (CodeTable[i].bits == TableBitsW'(bits))) begin
                ch = CodeTable[i].ch;
            end
        end
        return ch;
    endfunction

endpackage

/* hdl/msd_stream_if.sv */
// Valid/ready channel interfaces for the symbol byte input and the decoded character output.
interface msd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_byte;

    modport source (output valid, output symbol_byte, input ready);
    modport sink   (input valid, input symbol_byte, output ready);
endinterface

interface msd_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] decoded_char;

    modport source (output valid, output decoded_char, input ready);
    modport sink   (input valid, input decoded_char, output ready);
endinterface

/* hdl/morse_stream_decoder_core.sv */
// Morse stream decoder: input register, symbol buffer with table match, result register.
//
//  Channel     Direction  Payload              Transfers per item
//  symbol_in   in         symbol_byte [7:0]    exactly one
//  char_out    out        decoded_char [6:0]   zero or one
//
// One item can be taken in every cycle while the result register is free or being emptied.
// An item waits in the input register until it retires, and the character it produces is
// then loaded into the result register, which drives output valid.
// The rate is set by the single input register feeding the buffer update and table match.
// Reset clears the valid flags and the symbol buffer; the block is ready straight after.
// While a result waits unaccepted the input register may still fill once; further input
// is held off until char_out is taken.
module morse_stream_decoder_core (
    input logic          clk,
    input logic          rst_n,
    msd_byte_if.sink     symbol_in,
    msd_char_if.source   char_out
);

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Symbol buffer state.
    msd_pkg::pattern_t     pattern_bits_reg,   pattern_bits_next;
    msd_pkg::pattern_len_t pattern_length_reg, pattern_length_next;
    logic                  slash_seen_reg,     slash_seen_next;
    logic                  pattern_invalid_reg, pattern_invalid_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_char_reg;

    logic       stage_advance;
    logic       is_space;
    logic [6:0] match_char;
    logic [6:0] result_char;
    logic       emit;

    // The held item retires whenever the result register is free or being emptied.
    assign stage_advance   = in_valid_reg && (!out_valid_reg || char_out.ready);
    assign symbol_in.ready = !in_valid_reg || stage_advance;

    assign is_space   = (in_byte_reg == msd_pkg::AsciiSpace);
    assign match_char = msd_pkg::lookup_code(pattern_length_reg, pattern_bits_reg);

    // A letter containing the word mark is only valid as the mark on its own.
    always_comb
    begin
        result_char = msd_pkg::CharNone;
        if ((pattern_length_reg != '0) && !pattern_invalid_reg) begin
            if (slash_seen_reg) begin
                if (pattern_length_reg == msd_pkg::pattern_len_t'(1)) begin
                    result_char = msd_pkg::CharSpace;
                end
            end else begin
                result_char = match_char;
            end
        end
    end

    assign emit = stage_advance && is_space && (result_char != msd_pkg::CharNone);

    // Buffer update: a space clears everything; any other byte is shifted in unless the
    // buffer is already full, in which case the letter is marked invalid.
    always_comb
    begin
        pattern_bits_next    = pattern_bits_reg;
        pattern_length_next  = pattern_length_reg;
        slash_seen_next      = slash_seen_reg;
        pattern_invalid_next = pattern_invalid_reg;
        if (stage_advance) begin
            if (is_space) begin
                pattern_bits_next    = '0;
                pattern_length_next  = '0;
                slash_seen_next      = 1'b0;
                pattern_invalid_next = 1'b0;
            end else if (pattern_length_reg ==
                         msd_pkg::pattern_len_t'(msd_pkg::MaxCodeLen)) begin
                pattern_invalid_next = 1'b1;
            end else begin
                pattern_bits_next   = {pattern_bits_reg[msd_pkg::MaxCodeLen-2:0],
                                       (in_byte_reg == msd_pkg::AsciiDash)};
                pattern_length_next = pattern_length_reg + msd_pkg::pattern_len_t'(1);
                if (in_byte_reg == msd_pkg::AsciiSlash) begin
                    slash_seen_next = 1'b1;
                end else if ((in_byte_reg != msd_pkg::AsciiDot) &&
                             (in_byte_reg != msd_pkg::AsciiDash)) begin
                    pattern_invalid_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (char_out.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            pattern_bits_reg    <= '0;
            pattern_length_reg  <= '0;
            slash_seen_reg      <= 1'b0;
            pattern_invalid_reg <= 1'b0;
        end else begin
            if (symbol_in.ready) begin
                in_valid_reg <= symbol_in.valid;
            end
            out_valid_reg       <= out_valid_next;
            pattern_bits_reg    <= pattern_bits_next;
            pattern_length_reg  <= pattern_length_next;
            slash_seen_reg      <= slash_seen_next;
            pattern_invalid_reg <= pattern_invalid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (symbol_in.ready && symbol_in.valid) begin
            in_byte_reg <= symbol_in.symbol_byte;
        end
        if (emit) begin
            out_char_reg <= result_char;
        end
    end

    assign char_out.valid        = out_valid_reg;
    assign char_out.decoded_char = out_char_reg;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the Morse stream decoder: directed, random and stalled traffic.
`timescale 1ns / 100ps

module tb_top;

    // The watchdog gives up after this many cycles in which neither channel completes a
    // transfer. The slowest correct run sees the receiver hold-off of HoldOffLen and random
    // gaps, so this is many times the longest honest pause.
    localparam int StallLimit   = 4000;
    // Cycles allowed for stray results after the last expected character has arrived.
    localparam int DrainCycles  = 20;
    // Length of the deliberate receiver hold-off in the back-pressure test.
    localparam int HoldOffLen   = 300;

    logic clk;
    logic rst_n;

    msd_byte_if symbol_ch ();
    msd_char_if char_ch ();

    morse_stream_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol_in (symbol_ch.sink),
        .char_out  (char_ch.source)
    );

    // Clock with a period of 12 ns.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // The Morse table, in the order of the block's table. The first entry whose
    // pattern and length agree with the held symbols decides the character.
    string morse_codes [54] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
        "----.", "-----",
        ".-.-.-", "--..--", "..--..", ".----.", "-.-.-----.", "-..-.", "-.--.",
        "-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
        "..--.-", ".-..-.", "...-..-", ".--.-."
    };
    // One character per table entry, in the same order.
    string morse_chars = "abcdefghijklmnopqrstuvwxyz1234567890.,?'!/()&:;=+-_\"$@";

    // The predictor's own copy of the symbol buffer.
    logic [msd_pkg::MaxCodeLen-1:0] held_bits;
    int                             held_len;
    bit                             held_slash;
    bit                             held_bad;

    // Characters that the predictor has worked out and that have not yet been seen on
    // char_out, oldest first.
    logic [6:0] pending_chars [$];

    int error_count;
    int items_sent;

    // Idling rates of the two sides, in per cent of cycles.
    int send_idle_pct;
    int recv_idle_pct;

    // A hold-off is requested by bumping hold_request; the receiver process owns the
    // counting so that after the initial setup only one process drives char_ch.ready.
    int hold_request;
    int hold_taken;
    int hold_left;

    int quiet_cycles;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Looks the held dot/dash pattern up in the table; zero means no entry matches.
    function automatic logic [6:0] match_held_pattern();
        logic [msd_pkg::MaxCodeLen-1:0] bits;
        int                             len;
        byte unsigned                   c;
        for (int i = 0; i < 54; i++) begin
            bits = '0;
            len  = morse_codes[i].len();
            for (int k = 0; k < len; k++) begin
                bits = {bits[msd_pkg::MaxCodeLen-2:0],
                        (morse_codes[i][k] == msd_pkg::AsciiDash)};
            end
            if (len == held_len && bits == held_bits) begin
                c = morse_chars[i];
                return c[6:0];
            end
        end
        return msd_pkg::CharNone;
    endfunction

    // Applies one accepted byte to the predictor's buffer and returns the character it
    // causes, if any. Every space empties the buffer, whether or not it decodes.
    function automatic void decode_step(input logic [7:0] b, output bit emit,
                                        output logic [6:0] ch);
        emit = 1'b0;
        ch   = msd_pkg::CharNone;
        if (b != msd_pkg::AsciiSpace) begin
            if (held_len >= msd_pkg::MaxCodeLen) begin
                // A symbol beyond the buffer size is dropped but spoils the letter.
                held_bad = 1'b1;
            end else begin
                if (b == msd_pkg::AsciiSlash) begin
                    held_slash = 1'b1;
                end else if (b != msd_pkg::AsciiDot && b != msd_pkg::AsciiDash) begin
                    held_bad = 1'b1;
                end
                held_bits = {held_bits[msd_pkg::MaxCodeLen-2:0], (b == msd_pkg::AsciiDash)};
                held_len++;
            end
        end else begin
            if (held_len != 0 && !held_bad) begin
                if (held_slash) begin
                    // Only a lone word mark decodes; a slash mixed with anything is unknown.
                    if (held_len == 1) begin
                        ch   = msd_pkg::CharSpace;
                        emit = 1'b1;
                    end
                end else begin
                    ch   = match_held_pattern();
                    emit = (ch != msd_pkg::CharNone);
                end
            end
            held_bits  = '0;
            held_len   = 0;
            held_slash = 1'b0;
            held_bad   = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus: the shared sender
    // ------------------------------------------------------------------------------------

    // Offers one byte on symbol_in and returns at the falling edge after its transfer.
    // It is always entered at a falling edge. valid is left high on return so that a
    // following byte offered without a gap does not see valid lowered and raised again in
    // the same time step.
    task automatic send_symbol(input logic [7:0] b);
        bit         emit;
        logic [6:0] ch;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            symbol_ch.valid <= 1'b0;
            @(negedge clk);
        end
        symbol_ch.valid       <= 1'b1;
        symbol_ch.symbol_byte <= b;
        do begin
            @(posedge clk);
        end while (!symbol_ch.ready);
        decode_step(b, emit, ch);
        if (emit) begin
            pending_chars.push_back(ch);
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Sends a whole pattern and the space that ends it.
    task automatic send_letter(input string code);
        for (int k = 0; k < code.len(); k++) begin
            send_symbol(code[k]);
        end
        send_symbol(msd_pkg::AsciiSpace);
    endtask

    // A byte for a malformed letter: mostly dots and dashes, some slashes, and some
    // arbitrary bytes so that every bit of the field is exercised.
    function automatic logic [7:0] noise_symbol();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            return msd_pkg::AsciiDot;
        end else if (pick < 7) begin
            return msd_pkg::AsciiDash;
        end else if (pick == 7) begin
            return msd_pkg::AsciiSlash;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------------------

    // The receiver changes ready at the falling edge, either at random or held low for a
    // requested stretch.
    always @(negedge clk) begin
        if (!rst_n) begin
            char_ch.ready <= 1'b0;
        end else if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left  = HoldOffLen - 1;
            char_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            char_ch.ready <= 1'b0;
        end else begin
            char_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every output transfer is checked against the oldest pending character.
    always @(posedge clk) begin
        if (rst_n && char_ch.valid && char_ch.ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual 'h%0h",
                         $time, char_ch.decoded_char);
                error_count++;
            end else begin
                if (char_ch.decoded_char !== pending_chars[0]) begin
                    $display("%0t: decoded_char mismatch: expected 'h%0h, actual 'h%0h",
                             $time, pending_chars[0], char_ch.decoded_char);
                    error_count++;
                end
                void'(pending_chars.pop_front());
            end
        end
    end

    // Watchdog: a run that stops making transfers has hung.
    always @(posedge clk) begin
        if ((symbol_ch.valid && symbol_ch.ready) || (char_ch.valid && char_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("[morse_stream_decoder_core] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Short directed letters covering each corner of the decoder.
    task automatic test_directed();
        send_letter(".-");                   // a plain letter
        send_symbol(msd_pkg::AsciiSpace);    // an empty letter emits nothing
        send_letter("/");                    // a lone word mark decodes to a space
        send_letter("/.");                   // a slash with other symbols is unknown
        send_symbol(8'hFF);                  // a foreign byte spoils the letter
        send_letter(".");
        send_symbol(8'h00);                  // the lowest byte value is foreign too
        send_symbol(msd_pkg::AsciiSpace);
        send_letter("...........");          // eleven symbols overflow the buffer
    endtask

    // A random stream: mostly well-formed letters from the table, with word marks, and
    // the rest malformed letters that mix symbols, slashes, foreign bytes and overlong
    // runs. It stops once the given number of bytes has been transferred.
    task automatic test_random_stream(input int send_pct, input int recv_pct,
                                      input int item_count);
        int target;
        int kind;
        int len;
        target        = items_sent + item_count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_letter(morse_codes[$urandom_range(0, 53)]);
            end else if (kind < 78) begin
                send_letter("/");
            end else begin
                len = $urandom_range(0, 13);
                for (int k = 0; k < len; k++) begin
                    send_symbol(noise_symbol());
                end
                send_symbol(msd_pkg::AsciiSpace);
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering letters
    // that all decode, so the result register and the input register fill and the block
    // has to stall its input.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request++;
        for (int n = 0; n < 20; n++) begin
            send_letter(morse_codes[$urandom_range(0, 53)]);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------------------

    initial begin
        rst_n                 = 1'b0;
        symbol_ch.valid       = 1'b0;
        symbol_ch.symbol_byte = 8'h00;
        char_ch.ready         = 1'b0;
        held_bits             = '0;
        held_len              = 0;
        held_slash            = 1'b0;
        held_bad              = 1'b0;
        error_count           = 0;
        items_sent            = 0;
        send_idle_pct         = 0;
        recv_idle_pct         = 0;
        hold_request          = 0;
        hold_taken            = 0;
        hold_left             = 0;
        quiet_cycles          = 0;

        // Reset is held low from the start and released at a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 71;
        test_directed();
        test_random_stream(29, 71, 450);
        test_random_stream(71, 29, 450);
        test_random_stream(0, 0, 300);
        test_back_pressure();
        test_random_stream(0, 0, 100);

        symbol_ch.valid <= 1'b0;
        recv_idle_pct = 0;

        // Let every pending character arrive; the watchdog catches one that never does.
        while (pending_chars.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0) begin
            $display("[morse_stream_decoder_core] OK");
        end else begin
            $display("[morse_stream_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/msd_pkg.sv
hdl/msd_stream_if.sv
hdl/morse_stream_decoder_core.sv
tb/sv/tb_top.sv
